// ===== src/acfb_pkg.sv =====
`timescale 1ns / 1ps
package acfb_pkg;

  localparam int unsigned BlkBytes = 16;

  typedef logic [7:0]   byte_t;
  typedef logic [127:0] blk_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY0   = 3'd0;
  localparam logic [2:0] CFG_KEY1   = 3'd1;
  localparam logic [2:0] CFG_KEY2   = 3'd2;
  localparam logic [2:0] CFG_KEY3   = 3'd3;
  localparam logic [2:0] CFG_KSIZE  = 3'd4;
  localparam logic [2:0] CFG_IV_LO  = 3'd5;
  localparam logic [2:0] CFG_IV_HI  = 3'd6;

  localparam logic [1:0] KSIZE_128 = 2'd0;
  localparam logic [1:0] KSIZE_192 = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the input beat
    logic restart;    // reload feedback, clear keystream/offset, start key schedule
    logic ks_step;    // advance key schedule one word
    logic aes_start;  // load state = feedback ^ rk0
    logic aes_round;  // one round
    logic byte_step;  // process one plaintext byte
    logic out_load;   // move result to output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ks_done;
    logic aes_last;    // round being run is the final one
    logic need_aes;    // offset is zero
    logic bytes_done;  // no bytes left
  } stat_t;

  function automatic byte_t sbox(input byte_t x);
    byte_t t [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic byte_t xtime(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== src/acfb_ctrl.sv =====
`timescale 1ns / 1ps
module acfb_ctrl
  import acfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  in_restart,
  input  logic  out_free,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEYS, ST_CHECK, ST_ROUND, ST_BYTE, ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load    = 1'b1;
          cmd.restart = in_restart;
          state_nxt   = in_restart ? ST_KEYS : ST_CHECK;
        end
      end
      ST_KEYS: begin
        if (stat.ks_done) begin
          state_nxt = ST_CHECK;
        end else begin
          cmd.ks_step = 1'b1;
        end
      end
      ST_CHECK: begin
        if (stat.bytes_done) begin
          state_nxt = ST_DONE;
        end else if (stat.need_aes) begin
          cmd.aes_start = 1'b1;
          state_nxt     = ST_ROUND;
        end else begin
          state_nxt = ST_BYTE;
        end
      end
      ST_ROUND: begin
        cmd.aes_round = 1'b1;
        if (stat.aes_last) begin
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        cmd.byte_step = 1'b1;
        state_nxt     = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/acfb_dp.sv =====
`timescale 1ns / 1ps
module acfb_dp
  import acfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_sel,
  input  logic [63:0] cfg_data,
  input  logic [63:0] in_plain_low,
  input  logic [63:0] in_plain_high,
  input  logic [4:0]  in_byte_count,
  output logic [63:0] res_low,
  output logic [63:0] res_high,
  output logic [4:0]  res_count
);

  // Round keys: one 128-bit entry per round, filled one word per cycle by
  // the schedule, one entry read per round.
  blk_t         rk_r [15];
  logic [255:0] key_r;
  logic [1:0]   ksize_r;
  logic [127:0] iv_r;
  logic [1:0]   sel_r;     // latched at restart
  logic [5:0]   wi_r;      // key schedule word index
  logic [3:0]   nki_r;     // i mod nk
  logic [3:0]   rcidx_r;   // i / nk
  logic [31:0]  wlast_r;   // w[i-1]
  logic [255:0] wwin_r;    // last nk words (window, oldest in low)

  blk_t fb_r, ks_r, st_r;
  logic [3:0] off_r, rnd_r, pos_r;
  logic [4:0] cnt_r;
  logic [4:0] tot_r;       // saturated count of the beat in progress
  blk_t plain_r, ciph_r;
  logic [63:0] res_low_r, res_high_r;
  logic [4:0]  res_count_r;

  logic [3:0] nk, nrounds;
  logic [5:0] total;
  always_comb begin
    unique case (sel_r)
      KSIZE_128: begin nk = 4'd4; nrounds = 4'd10; end
      KSIZE_192: begin nk = 4'd6; nrounds = 4'd12; end
      default:   begin nk = 4'd8; nrounds = 4'd14; end
    endcase
    total = {nrounds, 2'b00} + 6'd4;
  end

  // Key schedule next word
  logic [7:0]  rcon;
  logic [31:0] t, wold, wnew;
  always_comb begin
    unique case (rcidx_r)
      4'd1: rcon = 8'h01; 4'd2: rcon = 8'h02; 4'd3: rcon = 8'h04;
      4'd4: rcon = 8'h08; 4'd5: rcon = 8'h10; 4'd6: rcon = 8'h20;
      4'd7: rcon = 8'h40; 4'd8: rcon = 8'h80; 4'd9: rcon = 8'h1b;
      4'd10: rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
    t = wlast_r;
    if (nki_r == 4'd0) begin
      t = {sbox(wlast_r[7:0]), sbox(wlast_r[31:24]), sbox(wlast_r[23:16]),
           sbox(wlast_r[15:8]) ^ rcon};
    end else if (nk == 4'd8 && nki_r == 4'd4) begin
      t = {sbox(wlast_r[31:24]), sbox(wlast_r[23:16]), sbox(wlast_r[15:8]),
           sbox(wlast_r[7:0])};
    end
    wold = wwin_r[31:0];
    wnew = wold ^ t;
  end

  assign stat.ks_done = (wi_r >= total);

  // AES round
  blk_t rk_cur, sr, mc, rnd_out;
  always_comb begin
    rk_cur = rk_r[rnd_r];
    for (int i = 0; i < 16; i++) begin
      sr[8*i +: 8] = sbox(st_r[8*((i % 4) + 4*(((i / 4) + (i % 4)) % 4)) +: 8]);
    end
    mc = sr;
    for (int c = 0; c < 4; c++) begin
      byte_t a0, a1, a2, a3, al;
      a0 = sr[32*c +: 8]; a1 = sr[32*c+8 +: 8];
      a2 = sr[32*c+16 +: 8]; a3 = sr[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      mc[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      mc[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    rnd_out = ((rnd_r == nrounds) ? sr : mc) ^ rk_cur;
  end
  assign stat.aes_last = (rnd_r == nrounds);
  assign stat.need_aes = (off_r == 4'd0);
  assign stat.bytes_done = (cnt_r == 5'd0);

  byte_t kb, pb;
  blk_t rk0;
  always_comb begin
    rk0 = rk_r[0];
    kb = ks_r[8*off_r +: 8] ^ plain_r[8*pos_r +: 8];
    pb = kb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      ksize_r <= KSIZE_128;
      iv_r    <= '0;
      fb_r    <= '0;
      ks_r    <= '0;
      off_r   <= '0;
      cnt_r   <= '0;
      sel_r   <= KSIZE_128;
      // reset state: the boot pass runs the schedule of the zero 128-bit key
      wi_r    <= 6'd4;
      nki_r   <= 4'd0;
      rcidx_r <= 4'd1;
      wlast_r <= '0;
      wwin_r  <= '0;
      rk_r[0] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_sel)
          CFG_KEY0:  key_r[63:0]    <= cfg_data;
          CFG_KEY1:  key_r[127:64]  <= cfg_data;
          CFG_KEY2:  key_r[191:128] <= cfg_data;
          CFG_KEY3:  key_r[255:192] <= cfg_data;
          CFG_KSIZE: ksize_r        <= cfg_data[1:0];
          CFG_IV_LO: iv_r[63:0]     <= cfg_data;
          CFG_IV_HI: iv_r[127:64]   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.restart) begin
        sel_r   <= (ksize_r == 2'd3) ? 2'd2 : ksize_r;
        fb_r    <= iv_r;
        ks_r    <= '0;
        off_r   <= '0;
        rk_r[0] <= key_r[127:0];
        rk_r[1] <= key_r[255:128];
        unique case (ksize_r)
          KSIZE_128: begin
            wi_r <= 6'd4; wlast_r <= key_r[127:96];
            wwin_r <= {128'd0, key_r[127:0]};
          end
          KSIZE_192: begin
            wi_r <= 6'd6; wlast_r <= key_r[191:160];
            wwin_r <= {64'd0, key_r[191:0]};
          end
          default: begin
            wi_r <= 6'd8; wlast_r <= key_r[255:224];
            wwin_r <= key_r;
          end
        endcase
        nki_r   <= 4'd0;
        rcidx_r <= 4'd1;
      end
      if (cmd.ks_step) begin
        rk_r[wi_r[5:2]][32*wi_r[1:0] +: 32] <= wnew;
        wlast_r    <= wnew;
        wi_r       <= wi_r + 6'd1;
        // shift window: new word goes in at slot nk-1
        unique case (nk)
          4'd4: wwin_r <= {128'd0, wnew, wwin_r[127:32]};
          4'd6: wwin_r <= {64'd0, wnew, wwin_r[191:32]};
          default: wwin_r <= {wnew, wwin_r[255:32]};
        endcase
        if (nki_r == nk - 4'd1) begin
          nki_r   <= 4'd0;
          rcidx_r <= rcidx_r + 4'd1;
        end else begin
          nki_r <= nki_r + 4'd1;
        end
      end
      if (cmd.load) begin
        cnt_r <= (in_byte_count > 5'd16) ? 5'd16 : in_byte_count;
      end
      if (cmd.aes_start) begin
        st_r  <= fb_r ^ rk0;
        rnd_r <= 4'd1;
      end
      if (cmd.aes_round) begin
        st_r  <= rnd_out;
        rnd_r <= rnd_r + 4'd1;
        if (stat.aes_last) ks_r <= rnd_out;
      end
      if (cmd.byte_step) begin
        ks_r[8*off_r +: 8] <= kb;
        ciph_r[8*pos_r +: 8] <= pb;
        pos_r <= pos_r + 4'd1;
        cnt_r <= cnt_r - 5'd1;
        off_r <= off_r + 4'd1;
        if (off_r == 4'd15) begin
          fb_r <= {kb, ks_r[119:0]};
        end
      end
    end
    // payload registers
    if (cmd.load) begin
      plain_r <= {in_plain_high, in_plain_low};
      ciph_r  <= '0;
      pos_r   <= '0;
      tot_r   <= (in_byte_count > 5'd16) ? 5'd16 : in_byte_count;
    end
    if (cmd.out_load) begin
      res_low_r   <= ciph_r[63:0];
      res_high_r  <= ciph_r[127:64];
      res_count_r <= tot_r;
    end
  end

  assign res_low   = res_low_r;
  assign res_high  = res_high_r;
  assign res_count = res_count_r;

endmodule

// ===== src/aes_cfb128_encrypt.sv =====
`timescale 1ns / 1ps
// AES-CFB128 encryptor, 128/192/256-bit keys. Each input beat carries up to 16
// plaintext bytes (byte 0 in bits 7:0) plus a count; the result beat returns
// the same number of ciphertext bytes, unused positions zero. Key, key size
// and IV are written through the cfg port while idle; the user must keep to
// that, as the block does not enforce it. They take effect on the next beat
// with restart set. After reset the block runs the key schedule for the
// all-zero 128-bit key before taking its first beat. A restart first runs
// the key schedule. Each byte takes a check, then Nr AES rounds whenever a
// fresh keystream block is needed (one AES round per cycle in a shared round
// unit), then a byte step. A beat adds its accept, a final check and the
// output load.
// The output register lets a finished beat wait while the next one is taken.
module aes_cfb128_encrypt
  import acfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_low,
  input  logic [63:0] in_plain_high,
  input  logic [4:0]  in_byte_count,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_low,
  output logic [63:0] out_cipher_high,
  output logic [4:0]  out_count
);

  cmd_t  cmd, cmd_dp;
  stat_t stat;
  logic  ctrl_ready, in_fire, out_free, out_valid_r;
  logic  boot_r;   // schedule of the reset key runs right after reset

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = ctrl_ready && !boot_r;
  assign in_fire  = in_valid && in_ready;

  acfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire || boot_r),
    .in_restart(in_restart || boot_r),
    .out_free  (out_free),
    .stat      (stat),
    .in_ready  (ctrl_ready),
    .cmd       (cmd)
  );

  // A boot pass is a restart with no bytes and no result.
  always_comb begin
    cmd_dp = cmd;
    if (boot_r) begin
      cmd_dp.load = 1'b0;
    end
  end

  acfb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd_dp),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_sel      (cfg_index),
    .cfg_data     (cfg_data),
    .in_plain_low (in_plain_low),
    .in_plain_high(in_plain_high),
    .in_byte_count(in_byte_count),
    .res_low      (out_cipher_low),
    .res_high     (out_cipher_high),
    .res_count    (out_count)
  );

  logic boot_busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_r      <= 1'b1;
      boot_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (boot_r && ctrl_ready) begin
        boot_r      <= 1'b0;
        boot_busy_r <= 1'b1;
      end
      if (boot_busy_r && cmd.out_load) begin
        boot_busy_r <= 1'b0;
      end
      if (cmd.out_load && !boot_busy_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Boot pass has no bytes, so its DONE drains into a dropped output.
  assign out_valid = out_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !cmd.byte_step)
    else $error("output load during byte step");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second beat taken while busy");

endmodule
